@@ hw/rtl/ring_buffer_deque_macros.svh @@
// Assertion macros shared by the ring buffer deque RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rbd_pkg.sv @@
// Package for the ring buffer deque: sizes, operation and status codes,
// request and result structs and the link type between storage cells.
// No dependencies.
package rbd_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CELL_CNT   = DEPTH - 1;

  typedef enum logic [1:0] {
    OP_PUSH_TAIL = 2'd0,
    OP_PUSH_HEAD = 2'd1,
    OP_POP_TAIL  = 2'd2,
    OP_POP_HEAD  = 2'd3
  } rbd_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } rbd_status_t;

  typedef struct packed {
    rbd_op_t            op;
    logic signed [31:0] push_value;
  } rbd_req_t;

  typedef struct packed {
    logic signed [31:0] pop_value;
    rbd_status_t        status;
    logic               is_empty;
    logic               is_full;
  } rbd_rsp_t;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] data;
  } rbd_link_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic    en;
    rbd_op_t op;
  } rbd_cmd_t;

endpackage

@@ hw/rtl/rbd_cell.sv @@
// One storage cell of the deque row: an entry and its valid bit.
// Depends on rbd_pkg.
module rbd_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbd_pkg::rbd_cmd_t             cmd,
  input  logic [rbd_pkg::DATA_WIDTH-1:0] push_data,
  input  rbd_pkg::rbd_link_t            left_link,
  input  rbd_pkg::rbd_link_t            right_link,
  output rbd_pkg::rbd_link_t            self_link,
  output logic                          valid_nxt_o,
  output logic [rbd_pkg::DATA_WIDTH-1:0] tap
);

  logic                           valid_r;
  logic                           valid_nxt;
  logic [rbd_pkg::DATA_WIDTH-1:0] data_r;
  logic [rbd_pkg::DATA_WIDTH-1:0] data_nxt;

  // Entries sit packed from the head end, so the tail entry is the valid
  // cell whose right neighbor is empty.
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    tap       = '0;
    if (cmd.en) begin
      case (cmd.op)
        rbd_pkg::OP_PUSH_TAIL: begin
          if (!valid_r && left_link.valid) begin
            valid_nxt = 1'b1;
            data_nxt  = push_data;
          end
        end
        rbd_pkg::OP_PUSH_HEAD: begin
          valid_nxt = left_link.valid;
          data_nxt  = left_link.data;
        end
        rbd_pkg::OP_POP_TAIL: begin
          if (valid_r && !right_link.valid) begin
            valid_nxt = 1'b0;
            tap       = data_r;
          end
        end
        rbd_pkg::OP_POP_HEAD: begin
          valid_nxt = right_link.valid;
          data_nxt  = right_link.data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign self_link.valid = valid_r;
  assign self_link.data  = data_r;
  assign valid_nxt_o     = valid_nxt;

endmodule

@@ hw/rtl/ring_buffer_deque.sv @@
// Top level of the ring buffer deque: a row of storage cells and a result register.
// Depends on rbd_pkg, rbd_cell and ring_buffer_deque_macros.svh.
//
// Usage:
//   A request on in_data carries an operation (push tail, push head, pop tail,
//   pop head) and a push value. It is taken when in_valid is high and in_stall
//   is low. Each request yields exactly one result on out_data: the popped
//   value (zero on pushes and on failed pops), a status (ok, overflow when
//   pushing into a full deque, underflow when popping an empty one) and the
//   empty and full flags after the request. The deque holds DEPTH-1 entries.
//   The result appears in the cycle after acceptance. Throughput is one
//   request per cycle while in_stall is low; every cell of the row updates
//   in the same cycle, shifting toward the head or tail or loading a pushed value.
//   When the receiver stalls, the result register holds its value and
//   in_stall is raised until that result is taken. Reset empties the deque
//   and drops any pending result; no clearing pass is needed.
`include "ring_buffer_deque_macros.svh"

module ring_buffer_deque (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rbd_pkg::rbd_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rbd_pkg::rbd_rsp_t out_data
);

  localparam int N = rbd_pkg::CELL_CNT;

  rbd_pkg::rbd_link_t             links [N];
  rbd_pkg::rbd_link_t             lefts [N];
  rbd_pkg::rbd_link_t             rights[N];
  logic [rbd_pkg::DATA_WIDTH-1:0] taps  [N];
  logic [N-1:0]                   valid_nxt_vec;
  logic [N-1:0]                   valid_vec;
  logic [rbd_pkg::DATA_WIDTH-1:0] push_data;
  logic [rbd_pkg::DATA_WIDTH-1:0] tail_data;
  logic [rbd_pkg::DATA_WIDTH-1:0] pop_data;

  rbd_pkg::rbd_cmd_t   cmd;
  rbd_pkg::rbd_status_t status;
  rbd_pkg::rbd_rsp_t   rsp_r;
  rbd_pkg::rbd_rsp_t   rsp_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                accept;
  logic                is_push;
  logic                cur_empty;
  logic                cur_full;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign push_data = rbd_pkg::DATA_WIDTH'(in_data.push_value);

  assign cur_empty = !links[0].valid;
  assign cur_full  = links[N-1].valid;
  assign is_push   = (in_data.op == rbd_pkg::OP_PUSH_TAIL) ||
                     (in_data.op == rbd_pkg::OP_PUSH_HEAD);

  always_comb begin
    status = rbd_pkg::ST_OK;
    if (is_push && cur_full) begin
      status = rbd_pkg::ST_OVERFLOW;
    end else if (!is_push && cur_empty) begin
      status = rbd_pkg::ST_UNDERFLOW;
    end
  end

  assign cmd.en = accept && (status == rbd_pkg::ST_OK);
  assign cmd.op = in_data.op;

  // The head end sees an always-valid left neighbor carrying the push value.
  generate
    for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign lefts[i].valid = 1'b1;
        assign lefts[i].data  = push_data;
      end else begin : g_mid
        assign lefts[i] = links[i-1];
      end
      if (i == N - 1) begin : g_tail
        assign rights[i].valid = 1'b0;
        assign rights[i].data  = '0;
      end else begin : g_inner
        assign rights[i] = links[i+1];
      end

      rbd_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .push_data   (push_data),
        .left_link   (lefts[i]),
        .right_link  (rights[i]),
        .self_link   (links[i]),
        .valid_nxt_o (valid_nxt_vec[i]),
        .tap         (taps[i])
      );

      assign valid_vec[i] = links[i].valid;
    end
  endgenerate

  // At most one cell drives its tap on a tail pop.
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < N; i++) begin
      tail_data = tail_data | taps[i];
    end
  end

  always_comb begin
    pop_data = '0;
    if (status == rbd_pkg::ST_OK) begin
      case (in_data.op)
        rbd_pkg::OP_POP_TAIL: pop_data = tail_data;
        rbd_pkg::OP_POP_HEAD: pop_data = links[0].data;
        default:              pop_data = '0;
      endcase
    end
  end

  always_comb begin
    rsp_nxt           = rsp_r;
    out_valid_nxt     = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt     = 1'b1;
      rsp_nxt.pop_value = signed'(32'(pop_data));
      rsp_nxt.status    = status;
      rsp_nxt.is_empty  = !valid_nxt_vec[0];
      rsp_nxt.is_full   = valid_nxt_vec[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = rsp_r;

  `RBD_ASSERT_NOW(a_packed_row, 1'b1, $onehot({1'b0, valid_vec} + (N+1)'(1)), "cells not packed from head")
  `RBD_ASSERT_NEXT(a_overflow_keeps, accept && is_push && cur_full, links[N-1].valid, "overflow changed state")
  `RBD_ASSERT_NEXT(a_underflow_keeps, accept && !is_push && cur_empty, !links[0].valid, "underflow changed state")
  `RBD_ASSERT_NEXT(a_result_follows, accept, out_valid_r, "accepted request gave no result")

endmodule

@@ verif/rbd_deque_checker.sv @@
// Checker for the ring buffer deque: watches both channels, predicts each result
// from its own copy of the ring and compares it field by field.
// Depends on rbd_pkg.
module rbd_deque_checker
  import rbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  rbd_req_t in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  rbd_rsp_t out_data,
  output int       fail_count,
  output int       pending_cnt,
  output int       checked_cnt
);

  logic [DATA_WIDTH-1:0] ring [DEPTH];
  int                    head_ix;
  int                    tail_ix;
  rbd_rsp_t              due_rsps[$];

  function automatic int step_fwd(int i);
    return (i + 1) % DEPTH;
  endfunction

  function automatic int step_back(int i);
    return (i + DEPTH - 1) % DEPTH;
  endfunction

  // Applies one request to the local ring and returns the result it must produce.
  function automatic rbd_rsp_t apply_deque_op(rbd_req_t req);
    rbd_rsp_t rsp;
    rsp        = '0;
    rsp.status = ST_OK;
    if (req.op == OP_PUSH_TAIL || req.op == OP_PUSH_HEAD) begin
      if (step_fwd(tail_ix) == head_ix) begin
        rsp.status = ST_OVERFLOW;
      end else if (req.op == OP_PUSH_TAIL) begin
        ring[tail_ix] = req.push_value;
        tail_ix       = step_fwd(tail_ix);
      end else begin
        head_ix       = step_back(head_ix);
        ring[head_ix] = req.push_value;
      end
    end else begin
      if (head_ix == tail_ix) begin
        rsp.status = ST_UNDERFLOW;
      end else if (req.op == OP_POP_TAIL) begin
        tail_ix       = step_back(tail_ix);
        rsp.pop_value = ring[tail_ix];
      end else begin
        rsp.pop_value = ring[head_ix];
        head_ix       = step_fwd(head_ix);
      end
    end
    rsp.is_empty = (head_ix == tail_ix);
    rsp.is_full  = (step_fwd(tail_ix) == head_ix);
    return rsp;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rbd_rsp_t want;
    if (!rst_n) begin
      head_ix = 0;
      tail_ix = 0;
      due_rsps.delete();
    end else begin
      // The expectation goes in first so that a same-edge result still finds it.
      if (in_valid && !in_stall) begin
        due_rsps = {due_rsps, apply_deque_op(in_data)};
      end
      if (out_valid && !out_stall) begin
        if (due_rsps.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = due_rsps.pop_front();
          check_field("pop_value", want.pop_value, out_data.pop_value);
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(out_data.is_full));
          checked_cnt++;
        end
      end
    end
    pending_cnt = due_rsps.size();
  end

endmodule

@@ verif/tb_ring_buffer_deque.sv @@
// Testbench top for the ring buffer deque: clock, reset, request stimulus and
// result stall pattern, with the verdict taken from rbd_deque_checker.
// Depends on rbd_pkg, ring_buffer_deque and rbd_deque_checker.
module tb_ring_buffer_deque;
  import rbd_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_CYCLES    = 60;
  localparam int RAND_PER_PHASE = 260;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  rbd_req_t in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rbd_rsp_t out_data;

  int send_idle_pct  = 8;
  int recv_stall_pct = 77;
  int hold_asks      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int reqs_sent      = 0;
  bit fill_mode      = 1'b1;
  int fail_count;
  int pending_cnt;
  int checked_cnt;

  always #5 clk = ~clk;

  ring_buffer_deque u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rbd_deque_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt),
    .checked_cnt (checked_cnt)
  );

  // Result stall: a long counted hold-off when asked for, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT,
             pending_cnt);
    $display("== FAIL ==");
    $finish;
  end

  function automatic rbd_req_t mk_req(rbd_op_t op, logic [31:0] val);
    rbd_req_t r;
    r.op         = op;
    r.push_value = val;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(7) != 0) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Filling leans toward pushes and draining toward pops, so the level swings
  // between empty and full; a tenth of requests ignore the bias.
  function automatic rbd_req_t random_req(bit filling);
    int roll;
    bit push;
    bit at_head;
    rbd_op_t op;
    roll    = $urandom_range(99);
    at_head = 1'($urandom_range(1));
    push    = (roll < 10) ? 1'($urandom_range(1)) : ((roll < 75) == filling);
    if (push) op = at_head ? OP_PUSH_HEAD : OP_PUSH_TAIL;
    else      op = at_head ? OP_POP_HEAD : OP_POP_TAIL;
    return mk_req(op, pick_value());
  endfunction

  task automatic send_req(rbd_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reqs_sent++;
  endtask

  task automatic run_random(int n);
    repeat (n) begin
      if ($urandom_range(23) == 0) fill_mode = ~fill_mode;
      send_req(random_req(fill_mode));
    end
  endtask

  // Stops offering requests until every outstanding result has been taken.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Pops on the empty deque, then one value in and out at each end.
    send_req(mk_req(OP_POP_TAIL, 32'h0000_0000));
    send_req(mk_req(OP_POP_HEAD, 32'hFFFF_FFFF));
    send_req(mk_req(OP_PUSH_TAIL, 32'h7FFF_FFFF));
    send_req(mk_req(OP_PUSH_HEAD, 32'h8000_0000));
    send_req(mk_req(OP_POP_TAIL, 32'h0000_0000));
    send_req(mk_req(OP_POP_HEAD, 32'h0000_0000));
    // Fill from both ends with walking bits, then push into the full deque.
    for (int i = 0; i < DEPTH - 1; i++) begin
      send_req(mk_req(i[0] ? OP_PUSH_HEAD : OP_PUSH_TAIL,
                      i[0] ? ~(32'h1 << i) : (32'h1 << (31 - i))));
    end
    send_req(mk_req(OP_PUSH_TAIL, 32'h1234_5678));
    send_req(mk_req(OP_PUSH_HEAD, 32'h8765_4321));
    send_req(mk_req(OP_POP_HEAD, 32'h0000_0000));
    send_req(mk_req(OP_POP_TAIL, 32'h0000_0000));

    run_random(RAND_PER_PHASE);
    wait_drained();

    send_idle_pct  = 77;
    recv_stall_pct = 8;
    run_random(RAND_PER_PHASE);
    wait_drained();

    // No idling; the receiver holds off at the start while requests keep coming.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asks++;
    run_random(RAND_PER_PHASE);
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Sent %0d requests: directed empty/full corners, then biased random ops",
             reqs_sent);
    $display("under three idle profiles and a %0d-cycle hold-off; %0d results compared.",
             HOLD_CYCLES, checked_cnt);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_cell.sv
hw/rtl/ring_buffer_deque.sv
verif/rbd_deque_checker.sv
verif/tb_ring_buffer_deque.sv
